[hw/rtl/gcr_pkg.sv]
// Shared types, constants and the 3x5 font table for the glyph cell rectangle generator.
// No dependencies; every other file uses this package.
`timescale 1ns / 1ps
`default_nettype none

package gcr_pkg;

  // Glyph geometry: 5 rows of 3 cells, cells numbered row by row, left to right
  localparam int GLYPH_ROWS = 5;
  localparam int GLYPH_COLS = 3;
  localparam int NCELL      = GLYPH_ROWS * GLYPH_COLS;

  localparam int COORD_W = 11;  // width of the corner fields
  localparam int CRD_W   = 15;  // signed working width for placement and clipping
  localparam int DIM_W   = 11;  // width of a size register
  localparam int CFG_AW  = 4;   // four registers at byte offsets 0, 4, 8, 12
  localparam int CFG_DW  = 32;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  // Register indexes (word address)
  localparam logic [1:0] REG_BOARD_W = 2'd0;
  localparam logic [1:0] REG_BOARD_H = 2'd1;
  localparam logic [1:0] REG_HUD_W   = 2'd2;
  localparam logic [1:0] REG_HUD_H   = 2'd3;

  // Character codes
  localparam logic [7:0] ASCII_0     = 8'h30;
  localparam logic [7:0] ASCII_9     = 8'h39;
  localparam logic [7:0] ASCII_UA    = 8'h41;
  localparam logic [7:0] ASCII_UZ    = 8'h5A;
  localparam logic [7:0] ASCII_LA    = 8'h61;
  localparam logic [7:0] ASCII_LZ    = 8'h7A;
  localparam logic [7:0] ASCII_DASH  = 8'h2D;
  localparam logic [7:0] ASCII_COLON = 8'h3A;
  localparam logic [7:0] CASE_OFS    = 8'h20;

  localparam int NGLYPH = 39;
  localparam logic [5:0] GLYPH_A     = 6'd10;
  localparam logic [5:0] GLYPH_DASH  = 6'd36;
  localparam logic [5:0] GLYPH_COLON = 6'd37;
  localparam logic [5:0] GLYPH_BLANK = 6'd38;

  typedef logic [NCELL-1:0] cell_mask_t;

  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
  } rect_t;

  // Clamped surface sizes, in the working width
  typedef struct packed {
    logic signed [CRD_W-1:0] board_w;
    logic signed [CRD_W-1:0] board_h;
    logic signed [CRD_W-1:0] hud_w;
    logic signed [CRD_W-1:0] hud_h;
  } dims_t;

  // One octal digit per row, top row in the top digit; MSB of a row is the left cell
  localparam logic [NCELL-1:0] FONT [NGLYPH] = '{
    15'o75557, 15'o26227, 15'o71747, 15'o71717, 15'o55711,
    15'o74717, 15'o74757, 15'o71111, 15'o75757, 15'o75717,
    15'o25755, 15'o65656, 15'o34443, 15'o65556, 15'o74647,
    15'o74644, 15'o34553, 15'o55755, 15'o72227, 15'o11152,
    15'o55655, 15'o44447, 15'o57755, 15'o57775, 15'o25552,
    15'o65644, 15'o25573, 15'o65655, 15'o34216, 15'o72222,
    15'o55557, 15'o55552, 15'o55775, 15'o55255, 15'o55222,
    15'o71247,
    15'o00700,
    15'o02020,
    15'o00000
  };

  // Glyph pattern for a character, lower case folded to upper case
  function automatic logic [NCELL-1:0] glyph_bits(input logic [7:0] c);
    logic [7:0] u;
    logic [5:0] idx;
    u = (c >= ASCII_LA && c <= ASCII_LZ) ? c - CASE_OFS : c;
    if (u >= ASCII_0 && u <= ASCII_9)
      idx = 6'(u - ASCII_0);
    else if (u >= ASCII_UA && u <= ASCII_UZ)
      idx = 6'(u - ASCII_UA) + GLYPH_A;
    else if (u == ASCII_DASH)
      idx = GLYPH_DASH;
    else if (u == ASCII_COLON)
      idx = GLYPH_COLON;
    else
      idx = GLYPH_BLANK;
    return FONT[idx];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/gcr_cfg_regs.sv]
// APB register file holding the two surface sizes, with clamping of the values in use.
// Depends on gcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcr_cfg_regs #(
  parameter int MAX_WIDTH  = gcr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gcr_pkg::MAX_HEIGHT_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [gcr_pkg::CFG_AW-1:0]  paddr,
  input  wire  [gcr_pkg::CFG_DW-1:0]  pwdata,
  output logic [gcr_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output gcr_pkg::dims_t              dims
);
  import gcr_pkg::*;

  localparam logic signed [CRD_W-1:0] MAXW = CRD_W'(MAX_WIDTH);
  localparam logic signed [CRD_W-1:0] MAXH = CRD_W'(MAX_HEIGHT);

  logic [DIM_W-1:0] board_w_r, board_h_r, hud_w_r, hud_h_r;
  logic             wr_en;
  logic [1:0]       reg_idx;

  function automatic logic signed [CRD_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                        input logic signed [CRD_W-1:0] hi);
    logic signed [CRD_W-1:0] s;
    s = signed'(CRD_W'(v));
    if (v == '0)
      return CRD_W'(1);
    else if (s > hi)
      return hi;
    else
      return s;
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_w_r <= DIM_RESET;
      board_h_r <= DIM_RESET;
      hud_w_r   <= DIM_RESET;
      hud_h_r   <= DIM_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BOARD_W: board_w_r <= pwdata[DIM_W-1:0];
        REG_BOARD_H: board_h_r <= pwdata[DIM_W-1:0];
        REG_HUD_W:   hud_w_r   <= pwdata[DIM_W-1:0];
        REG_HUD_H:   hud_h_r   <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BOARD_W: prdata = CFG_DW'(board_w_r);
      REG_BOARD_H: prdata = CFG_DW'(board_h_r);
      REG_HUD_W:   prdata = CFG_DW'(hud_w_r);
      REG_HUD_H:   prdata = CFG_DW'(hud_h_r);
      default:     prdata = '0;
    endcase
  end

  assign dims.board_w = clamp_dim(board_w_r, MAXW);
  assign dims.board_h = clamp_dim(board_h_r, MAXH);
  assign dims.hud_w   = clamp_dim(hud_w_r, MAXW);
  assign dims.hud_h   = clamp_dim(hud_h_r, MAXH);

endmodule

`default_nettype wire

[hw/rtl/gcr_cell_lanes.sv]
// Fifteen parallel cell lanes: glyph lookup, square placement and clipping per cell.
// Purely combinational; depends on gcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcr_cell_lanes (
  input  wire  [7:0]                   char_code,
  input  wire  signed [11:0]           pos_x,
  input  wire  signed [11:0]           pos_y,
  input  wire  [3:0]                   scale,
  input  wire                          surface,
  input  gcr_pkg::dims_t               dims,
  output gcr_pkg::rect_t               rects [gcr_pkg::NCELL],
  output gcr_pkg::cell_mask_t          hit
);
  import gcr_pkg::*;

  logic [NCELL-1:0]        glyph;
  logic signed [CRD_W-1:0] px, py, sc, w, h;

  assign glyph = glyph_bits(char_code);
  assign px    = CRD_W'(pos_x);
  assign py    = CRD_W'(pos_y);
  assign sc    = signed'(CRD_W'(scale));
  assign w     = surface ? dims.hud_w : dims.board_w;
  assign h     = surface ? dims.hud_h : dims.board_h;

  for (genvar k = 0; k < NCELL; k++) begin : g_lane
    localparam int ROW = k / GLYPH_COLS;
    localparam int COL = k % GLYPH_COLS;

    logic signed [CRD_W-1:0] x0, y0, x1, y1, x0c, y0c, x1c, y1c;

    always_comb begin
      x0  = px + sc * signed'(CRD_W'(COL));
      y0  = py + sc * signed'(CRD_W'(ROW));
      x1  = x0 + sc;
      y1  = y0 + sc;
      x0c = (x0 < 0) ? '0 : x0;
      y0c = (y0 < 0) ? '0 : y0;
      x1c = (x1 > w) ? w : x1;
      y1c = (y1 > h) ? h : y1;
    end

    // pattern MSB is the top-left cell
    assign hit[k]      = glyph[NCELL-1-k] && (x1c > x0c) && (y1c > y0c);
    assign rects[k].x0 = x0c[COORD_W-1:0];
    assign rects[k].y0 = y0c[COORD_W-1:0];
    assign rects[k].x1 = x1c[COORD_W-1:0];
    assign rects[k].y1 = y1c[COORD_W-1:0];
  end

endmodule

`default_nettype wire

[hw/rtl/gcr_rect_queue.sv]
// Rectangle bank for one character and the emitter that sends one rectangle per cycle.
// Depends on gcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcr_rect_queue (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              load,
  input  gcr_pkg::rect_t                   rects [gcr_pkg::NCELL],
  input  gcr_pkg::cell_mask_t              hit,
  input  wire                              surface,
  input  wire  [7:0]                       color,
  output logic                             ready,
  output logic                             out_valid,
  output logic [gcr_pkg::COORD_W-1:0]      out_rect_x0,
  output logic [gcr_pkg::COORD_W-1:0]      out_rect_y0,
  output logic [gcr_pkg::COORD_W-1:0]      out_rect_x1,
  output logic [gcr_pkg::COORD_W-1:0]      out_rect_y1,
  output logic                             out_surface,
  output logic [7:0]                       out_color,
  output logic                             out_last_rect
);
  import gcr_pkg::*;

  rect_t      bank_r [NCELL];
  cell_mask_t mask_r, mask_nxt, pick, rest;
  logic       surf_r;
  logic [7:0] color_r;
  rect_t      sel;

  logic       out_valid_r, out_last_r, out_surf_r;
  rect_t      out_rect_r;
  logic [7:0] out_color_r;

  // lowest pending cell goes out first
  assign pick     = mask_r & (~mask_r + NCELL'(1));
  assign rest     = mask_r & ~pick;
  assign ready    = (rest == '0);
  assign mask_nxt = load ? hit : rest;

  always_comb begin
    sel = '0;
    for (int k = 0; k < NCELL; k++)
      sel = sel | (bank_r[k] & {$bits(rect_t){pick[k]}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= |mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bank_r  <= rects;
      surf_r  <= surface;
      color_r <= color;
    end
    out_rect_r  <= sel;
    out_surf_r  <= surf_r;
    out_color_r <= color_r;
    out_last_r  <= (rest == '0);
  end

  assign out_valid     = out_valid_r;
  assign out_rect_x0   = out_rect_r.x0;
  assign out_rect_y0   = out_rect_r.y0;
  assign out_rect_x1   = out_rect_r.x1;
  assign out_rect_y1   = out_rect_r.y1;
  assign out_surface   = out_surf_r;
  assign out_color     = out_color_r;
  assign out_last_rect = out_last_r;

endmodule

`default_nettype wire

[hw/rtl/glyph_cell_rect_generator_unit.sv]
// Top level of the 3x5 glyph cell rectangle generator.
// Depends on gcr_pkg, gcr_cfg_regs, gcr_cell_lanes and gcr_rect_queue.
`timescale 1ns / 1ps
`default_nettype none

// A character request is taken when start is high and busy is low. It is
// registered, all fifteen glyph cells are placed and clipped in parallel, and
// the surviving rectangles go out one per cycle on out_valid, top row first,
// left to right, the last one flagged by out_last_rect. A request crosses the
// input register, the rectangle bank and the output register before its first
// rectangle is on the result ports. The emitter sends a character's visible
// cells (up to 15) one at a time through the single result port; a character
// with no visible cell (blank, zero scale or fully clipped) sends nothing.
// One character can wait in the input register while the bank emits; busy is
// high only while that register is full and the bank still holds more than
// one pending rectangle, so a waiting character moves into the bank, and the
// next request is taken, in the cycle in which the bank sends its last
// rectangle. out_valid is not held off by the receiver: every rectangle is
// valid for exactly one cycle. The user must write the size registers over
// the APB port only while the block is idle; the block does not enforce it.

module glyph_cell_rect_generator_unit #(
  parameter int MAX_WIDTH  = gcr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gcr_pkg::MAX_HEIGHT_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire  [7:0]                      in_char_code,
  input  wire  signed [11:0]              in_pos_x,
  input  wire  signed [11:0]              in_pos_y,
  input  wire  [3:0]                      in_scale,
  input  wire                             in_surface,
  input  wire  [7:0]                      in_color,
  output logic                            out_valid,
  output logic [gcr_pkg::COORD_W-1:0]     out_rect_x0,
  output logic [gcr_pkg::COORD_W-1:0]     out_rect_y0,
  output logic [gcr_pkg::COORD_W-1:0]     out_rect_x1,
  output logic [gcr_pkg::COORD_W-1:0]     out_rect_y1,
  output logic                            out_surface,
  output logic [7:0]                      out_color,
  output logic                            out_last_rect,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [gcr_pkg::CFG_AW-1:0]      paddr,
  input  wire  [gcr_pkg::CFG_DW-1:0]      pwdata,
  output logic [gcr_pkg::CFG_DW-1:0]      prdata,
  output logic                            pready
);
  import gcr_pkg::*;

  logic               in_valid_r, in_valid_nxt;
  logic [7:0]         char_r;
  logic signed [11:0] pos_x_r, pos_y_r;
  logic [3:0]         scale_r;
  logic               surf_r;
  logic [7:0]         color_r;

  dims_t      dims;
  rect_t      rects [NCELL];
  cell_mask_t hit;
  logic       q_ready, load, accept;

  assign load   = in_valid_r && q_ready;
  assign busy   = in_valid_r && !q_ready;
  assign accept = start && !busy;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept)
      in_valid_nxt = 1'b1;
    else if (load)
      in_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      in_valid_r <= 1'b0;
    else
      in_valid_r <= in_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r  <= in_char_code;
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      scale_r <= in_scale;
      surf_r  <= in_surface;
      color_r <= in_color;
    end
  end

  gcr_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims    (dims)
  );

  gcr_cell_lanes u_lanes (
    .char_code (char_r),
    .pos_x     (pos_x_r),
    .pos_y     (pos_y_r),
    .scale     (scale_r),
    .surface   (surf_r),
    .dims      (dims),
    .rects     (rects),
    .hit       (hit)
  );

  gcr_rect_queue u_queue (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .rects         (rects),
    .hit           (hit),
    .surface       (surf_r),
    .color         (color_r),
    .ready         (q_ready),
    .out_valid     (out_valid),
    .out_rect_x0   (out_rect_x0),
    .out_rect_y0   (out_rect_y0),
    .out_rect_x1   (out_rect_x1),
    .out_rect_y1   (out_rect_y1),
    .out_surface   (out_surface),
    .out_color     (out_color),
    .out_last_rect (out_last_rect)
  );

endmodule

`default_nettype wire

[hw/rtl/gcr_port_checker.sv]
// Port-level checks for the glyph cell rectangle generator, bound to the top level.
// Depends on gcr_pkg and glyph_cell_rect_generator_unit.
`timescale 1ns / 1ps
`default_nettype none

module gcr_port_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         busy,
  input wire                         out_valid,
  input wire                         out_last_rect,
  input wire [gcr_pkg::COORD_W-1:0]  out_rect_x0,
  input wire [gcr_pkg::COORD_W-1:0]  out_rect_y0,
  input wire [gcr_pkg::COORD_W-1:0]  out_rect_x1,
  input wire [gcr_pkg::COORD_W-1:0]  out_rect_y1
);

  // nothing pending straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("output or busy active after reset");

  // a character's rectangles leave back to back until the flagged one
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_rect |=> out_valid)
    else $error("gap inside a character's rectangles");

  // only non-empty rectangles are sent
  a_rect_x_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rect_x1 > out_rect_x0)
    else $error("rectangle with empty width");

  a_rect_y_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rect_y1 > out_rect_y0)
    else $error("rectangle with empty height");

endmodule

bind glyph_cell_rect_generator_unit gcr_port_checker u_port_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_last_rect (out_last_rect),
  .out_rect_x0   (out_rect_x0),
  .out_rect_y0   (out_rect_y0),
  .out_rect_x1   (out_rect_x1),
  .out_rect_y1   (out_rect_y1)
);

`default_nettype wire

[tb/sv/gcr_rect_checker.sv]
// Checker for the glyph cell rectangle generator: predicts the rectangles of each request and
// compares them with the result channel. Depends on gcr_pkg only.
`timescale 1ns / 1ps

module gcr_rect_checker #(
  parameter int MAX_WIDTH  = gcr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gcr_pkg::MAX_HEIGHT_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire                          busy,
  input  wire  [7:0]                   in_char_code,
  input  wire  signed [11:0]           in_pos_x,
  input  wire  signed [11:0]           in_pos_y,
  input  wire  [3:0]                   in_scale,
  input  wire                          in_surface,
  input  wire  [7:0]                   in_color,
  input  wire                          out_valid,
  input  wire  [gcr_pkg::COORD_W-1:0]  out_rect_x0,
  input  wire  [gcr_pkg::COORD_W-1:0]  out_rect_y0,
  input  wire  [gcr_pkg::COORD_W-1:0]  out_rect_x1,
  input  wire  [gcr_pkg::COORD_W-1:0]  out_rect_y1,
  input  wire                          out_surface,
  input  wire  [7:0]                   out_color,
  input  wire                          out_last_rect,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [gcr_pkg::CFG_AW-1:0]   paddr,
  input  wire  [gcr_pkg::CFG_DW-1:0]   pwdata,
  input  wire                          pready,
  output int                           fail_count,
  output int                           pending,
  output int                           rects_checked
);

  import gcr_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    rect_t      box;
    logic       surface;
    logic [7:0] color;
    logic       last;
  } drawn_rect_t;

  drawn_rect_t      pending_rects [$];
  logic [DIM_W-1:0] dim_reg [4];
  int               n_bad = 0;
  int               n_checked = 0;

  // Row 0 in the top three bits, left cell first; lower case maps to the same pattern
  function automatic cell_mask_t glyph_pattern(input logic [7:0] ch);
    case (ch)
      "0": return 15'o75557;
      "1": return 15'o26227;
      "2": return 15'o71747;
      "3": return 15'o71717;
      "4": return 15'o55711;
      "5": return 15'o74717;
      "6": return 15'o74757;
      "7": return 15'o71111;
      "8": return 15'o75757;
      "9": return 15'o75717;
      "A", "a": return 15'o25755;
      "B", "b": return 15'o65656;
      "C", "c": return 15'o34443;
      "D", "d": return 15'o65556;
      "E", "e": return 15'o74647;
      "F", "f": return 15'o74644;
      "G", "g": return 15'o34553;
      "H", "h": return 15'o55755;
      "I", "i": return 15'o72227;
      "J", "j": return 15'o11152;
      "K", "k": return 15'o55655;
      "L", "l": return 15'o44447;
      "M", "m": return 15'o57755;
      "N", "n": return 15'o57775;
      "O", "o": return 15'o25552;
      "P", "p": return 15'o65644;
      "Q", "q": return 15'o25573;
      "R", "r": return 15'o65655;
      "S", "s": return 15'o34216;
      "T", "t": return 15'o72222;
      "U", "u": return 15'o55557;
      "V", "v": return 15'o55552;
      "W", "w": return 15'o55775;
      "X", "x": return 15'o55255;
      "Y", "y": return 15'o55222;
      "Z", "z": return 15'o71247;
      "-": return 15'o00700;
      ":": return 15'o02020;
      default: return '0;
    endcase
  endfunction

  function automatic int fit_dim(input logic [DIM_W-1:0] v, input int hi);
    int d;
    d = int'(v);
    if (d < 1) return 1;
    if (d > hi) return hi;
    return d;
  endfunction

  task automatic place_glyph_rects(input logic [7:0] ch, input logic signed [11:0] px,
                                   input logic signed [11:0] py, input logic [3:0] sc,
                                   input logic surf, input logic [7:0] color);
    cell_mask_t  glyph;
    drawn_rect_t hits [NCELL];
    drawn_rect_t r;
    int n, k, row, col, w, h, x0, y0, x1, y1, pxi, pyi, sci;
    glyph = glyph_pattern(ch);
    pxi = int'(px);
    pyi = int'(py);
    sci = int'(sc);
    w = fit_dim(surf ? dim_reg[REG_HUD_W] : dim_reg[REG_BOARD_W], MAX_WIDTH);
    h = fit_dim(surf ? dim_reg[REG_HUD_H] : dim_reg[REG_BOARD_H], MAX_HEIGHT);
    n = 0;
    if (sci != 0) begin
      for (k = 0; k < NCELL; k++) begin
        if (glyph[NCELL-1-k]) begin
          row = k / GLYPH_COLS;
          col = k % GLYPH_COLS;
          x0 = pxi + col * sci;
          y0 = pyi + row * sci;
          x1 = x0 + sci;
          y1 = y0 + sci;
          if (x0 < 0) x0 = 0;
          if (y0 < 0) y0 = 0;
          if (x1 > w) x1 = w;
          if (y1 > h) y1 = h;
          // squares clipped away entirely never count towards the last flag
          if (x1 > x0 && y1 > y0) begin
            r.box     = {11'(x0), 11'(y0), 11'(x1), 11'(y1)};
            r.surface = surf;
            r.color   = color;
            r.last    = 1'b0;
            hits[n]   = r;
            n++;
          end
        end
      end
    end
    for (k = 0; k < n; k++) begin
      r      = hits[k];
      r.last = (k == n - 1);
      pending_rects.push_back(r);
    end
  endtask

  task automatic report_rect(input bit have_want, input drawn_rect_t want,
                             input drawn_rect_t got);
    if (n_bad <= MAX_REPORTS) begin
      if (have_want)
        $display("%0t rect mismatch: expected x0=%0d y0=%0d x1=%0d y1=%0d surf=%0d col=%0d last=%0d",
                 $time, want.box.x0, want.box.y0, want.box.x1, want.box.y1,
                 want.surface, want.color, want.last);
      else
        $display("%0t rect with no request outstanding", $time);
      $display("    actual   x0=%0d y0=%0d x1=%0d y1=%0d surf=%0d col=%0d last=%0d",
               got.box.x0, got.box.y0, got.box.x1, got.box.y1,
               got.surface, got.color, got.last);
    end
  endtask

  always @(posedge clk) begin : monitor
    drawn_rect_t got, want;
    int i;
    if (!rst_n) begin
      pending_rects.delete();
      for (i = 0; i < 4; i++) dim_reg[i] = DIM_RESET;
    end else begin
      // results first: a rectangle at this edge belongs to an older request
      if (out_valid) begin
        got.box     = {out_rect_x0, out_rect_y0, out_rect_x1, out_rect_y1};
        got.surface = out_surface;
        got.color   = out_color;
        got.last    = out_last_rect;
        n_checked++;
        if (pending_rects.size() == 0) begin
          n_bad++;
          report_rect(1'b0, '0, got);
        end else begin
          want = pending_rects.pop_front();
          if (got.box.x0 !== want.box.x0 || got.box.y0 !== want.box.y0 ||
              got.box.x1 !== want.box.x1 || got.box.y1 !== want.box.y1 ||
              got.surface !== want.surface || got.color !== want.color ||
              got.last !== want.last) begin
            n_bad++;
            report_rect(1'b1, want, got);
          end
        end
      end
      if (psel && penable && pwrite && pready)
        dim_reg[paddr[CFG_AW-1:2]] = pwdata[DIM_W-1:0];
      if (start && !busy)
        place_glyph_rects(in_char_code, in_pos_x, in_pos_y, in_scale, in_surface, in_color);
    end
    fail_count    <= n_bad;
    pending       <= pending_rects.size();
    rects_checked <= n_checked;
  end

endmodule

[tb/sv/tb_glyph_cell_rect_generator_unit.sv]
// Top of the glyph cell rectangle generator testbench: clock, reset, request and register
// stimulus, verdict. Depends on gcr_pkg, gcr_rect_checker and the RTL top level.
`timescale 1ns / 1ps

module tb_glyph_cell_rect_generator_unit;

  import gcr_pkg::*;

  localparam int RESET_CYCLES    = 11;
  localparam int DRAIN_CYCLES    = 24;
  localparam int NPHASE          = 7;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int TIMEOUT_NS      = 2_000_000;
  localparam logic SURF_BOARD    = 1'b0;
  localparam logic SURF_HUD      = 1'b1;

  typedef struct packed {
    logic [7:0]         ch;
    logic signed [11:0] px;
    logic signed [11:0] py;
    logic [3:0]         sc;
    logic               surf;
    logic [7:0]         color;
  } char_req_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  wire                busy;
  logic [7:0]         in_char_code;
  logic signed [11:0] in_pos_x;
  logic signed [11:0] in_pos_y;
  logic [3:0]         in_scale;
  logic               in_surface;
  logic [7:0]         in_color;
  wire                out_valid;
  wire [COORD_W-1:0]  out_rect_x0;
  wire [COORD_W-1:0]  out_rect_y0;
  wire [COORD_W-1:0]  out_rect_x1;
  wire [COORD_W-1:0]  out_rect_y1;
  wire                out_surface;
  wire [7:0]          out_color;
  wire                out_last_rect;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [CFG_AW-1:0]  paddr;
  logic [CFG_DW-1:0]  pwdata;
  wire [CFG_DW-1:0]   prdata;
  wire                pready;

  int fail_count;
  int pending;
  int rects_checked;
  int requests_sent = 0;
  int cur_w [2];
  int cur_h [2];
  string glyph_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-:";

  glyph_cell_rect_generator_unit #(
    .MAX_WIDTH (MAX_WIDTH_DEF),
    .MAX_HEIGHT(MAX_HEIGHT_DEF)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_char_code (in_char_code),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_scale     (in_scale),
    .in_surface   (in_surface),
    .in_color     (in_color),
    .out_valid    (out_valid),
    .out_rect_x0  (out_rect_x0),
    .out_rect_y0  (out_rect_y0),
    .out_rect_x1  (out_rect_x1),
    .out_rect_y1  (out_rect_y1),
    .out_surface  (out_surface),
    .out_color    (out_color),
    .out_last_rect(out_last_rect),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  gcr_rect_checker #(
    .MAX_WIDTH (MAX_WIDTH_DEF),
    .MAX_HEIGHT(MAX_HEIGHT_DEF)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_char_code (in_char_code),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_scale     (in_scale),
    .in_surface   (in_surface),
    .in_color     (in_color),
    .out_valid    (out_valid),
    .out_rect_x0  (out_rect_x0),
    .out_rect_y0  (out_rect_y0),
    .out_rect_x1  (out_rect_x1),
    .out_rect_y1  (out_rect_y1),
    .out_surface  (out_surface),
    .out_color    (out_color),
    .out_last_rect(out_last_rect),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .rects_checked(rects_checked)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic char_req_t mk_req(input logic [7:0] ch, input int px, input int py,
                                       input int sc, input logic surf,
                                       input logic [7:0] color);
    char_req_t r;
    r.ch    = ch;
    r.px    = 12'(px);
    r.py    = 12'(py);
    r.sc    = 4'(sc);
    r.surf  = surf;
    r.color = color;
    return r;
  endfunction

  function automatic int fit_dim(input int v);
    int d;
    d = v % 2048;
    if (d < 1) return 1;
    if (d > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return d;
  endfunction

  // Mostly real glyphs placed around the surface so that clipping hits every side
  function automatic char_req_t random_req();
    char_req_t r;
    int w, h;
    if ($urandom_range(99) < 70)
      r.ch = glyph_chars[$urandom_range(glyph_chars.len() - 1)];
    else
      r.ch = 8'($urandom_range(255));
    r.surf = 1'($urandom_range(1));
    w = cur_w[r.surf];
    h = cur_h[r.surf];
    if ($urandom_range(99) < 75) begin
      r.px = 12'($urandom_range(w + 50) - 45);
      r.py = 12'($urandom_range(h + 50) - 45);
    end else begin
      r.px = 12'($urandom);
      r.py = 12'($urandom);
    end
    r.sc    = ($urandom_range(99) < 8) ? 4'd0 : 4'($urandom_range(15, 1));
    r.color = 8'($urandom_range(255));
    return r;
  endfunction

  task automatic drive_fields(input char_req_t r);
    in_char_code <= r.ch;
    in_pos_x     <= r.px;
    in_pos_y     <= r.py;
    in_scale     <= r.sc;
    in_surface   <= r.surf;
    in_color     <= r.color;
  endtask

  task automatic send_char(input char_req_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      drive_fields(random_req());
    end
    @(negedge clk);
    start <= 1'b1;
    drive_fields(r);
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  // drop start, let every outstanding rectangle arrive, then give the pipeline time to empty
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~32'h7FF) | (value & 32'h7FF);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_dims(input int bw, input int bh, input int hw, input int hh);
    wait_idle();
    apb_write(REG_BOARD_W, bw);
    apb_write(REG_BOARD_H, bh);
    apb_write(REG_HUD_W, hw);
    apb_write(REG_HUD_H, hh);
    cur_w[SURF_BOARD] = fit_dim(bw);
    cur_h[SURF_BOARD] = fit_dim(bh);
    cur_w[SURF_HUD]   = fit_dim(hw);
    cur_h[SURF_HUD]   = fit_dim(hh);
  endtask

  initial begin : stimulus
    int p, i, idle_pct;
    int idle_by_phase [3];
    idle_by_phase = '{0, 55, 16};
    rst_n = 1'b0;
    start = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_char_code = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_scale = '0;
    in_surface = 1'b0;
    in_color = '0;
    for (i = 0; i < 2; i++) begin
      cur_w[i] = MAX_WIDTH_DEF;
      cur_h[i] = MAX_HEIGHT_DEF;
    end
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every glyph class, clipping on each side, empty cases
    send_char(mk_req("0", 0, 0, 1, SURF_BOARD, 8'h00), 0);
    send_char(mk_req("8", -2048, -2048, 15, SURF_BOARD, 8'hFF), 0);
    send_char(mk_req("8", 2047, 2047, 15, SURF_HUD, 8'h01), 0);
    send_char(mk_req("W", -7, -7, 15, SURF_BOARD, 8'h5A), 0);
    send_char(mk_req("M", 1015, 1015, 15, SURF_HUD, 8'hA5), 0);
    send_char(mk_req("A", 100, 100, 0, SURF_BOARD, 8'h07), 0);
    send_char(mk_req(" ", 10, 10, 5, SURF_BOARD, 8'h03), 0);
    send_char(mk_req(8'h00, 0, 0, 15, SURF_HUD, 8'h00), 0);
    send_char(mk_req(8'hFF, 5, 5, 15, SURF_BOARD, 8'hFF), 0);
    send_char(mk_req("a", 20, 20, 3, SURF_BOARD, 8'h01), 0);
    send_char(mk_req("z", 30, 0, 4, SURF_HUD, 8'h02), 0);
    send_char(mk_req("Z", -2, 1, 2, SURF_BOARD, 8'h80), 0);
    send_char(mk_req("-", 0, 300, 7, SURF_HUD, 8'h7F), 0);
    send_char(mk_req(":", 512, 512, 9, SURF_BOARD, 8'h55), 0);
    send_char(mk_req("9", 1000, 0, 15, SURF_BOARD, 8'hAA), 0);
    send_char(mk_req("q", -1, -1, 1, SURF_HUD, 8'h09), 0);
    send_char(mk_req("X", -1, -1, 1, SURF_BOARD, 8'h0A), 0);
    send_char(mk_req("j", 1021, 1021, 1, SURF_HUD, 8'h0B), 0);
    send_char(mk_req("s", 2000, -2000, 15, SURF_BOARD, 8'h0C), 0);
    send_char(mk_req("4", -45, 0, 15, SURF_HUD, 8'h0D), 0);
    send_char(mk_req("1", 0, -30, 15, SURF_BOARD, 8'h0E), 0);

    for (p = 0; p < NPHASE; p++) begin
      case (p)
        1: set_dims(1, 1, 0, 2047);
        2: set_dims(40, 24, 17, 9);
        3: set_dims(1023, 1, 1, 1023);
        4: set_dims($urandom_range(64, 1), $urandom_range(64, 1),
                    $urandom_range(64, 1), $urandom_range(64, 1));
        5: set_dims($urandom_range(2047), $urandom_range(2047),
                    $urandom_range(2047), $urandom_range(2047));
        6: set_dims(1024, 1024, 1024, 1024);
        default: ;
      endcase
      idle_pct = idle_by_phase[p % 3];
      for (i = 0; i < ITEMS_PER_PHASE; i++) send_char(random_req(), idle_pct);
    end

    wait_idle();
    $display("Sent %0d character requests over %0d surface size settings; %0d rectangles checked,",
             requests_sent, NPHASE, rects_checked);
    $display("covering clipping on all sides, blank and unknown codes, and zero scale.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d bad rectangles, %0d never arrived", fail_count, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout: run did not complete, %0d requests sent", requests_sent);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
